/* rtl/core/fpa_pkg.sv */
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    // dividend a * 2^FRAC_BITS in magnitude form
    localparam int DIV_WIDTH  = DATA_WIDTH + FRAC_BITS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_MIN      = 4'd4,
        FN_MAX      = 4'd5,
        FN_LT       = 4'd6,
        FN_GT       = 4'd7,
        FN_LE       = 4'd8,
        FN_GE       = 4'd9,
        FN_EQ       = 4'd10,
        FN_NE       = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } func_t;

    typedef struct packed {
        logic [3:0]                   func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic                         compare_flag;
        logic                         divide_by_zero;
    } out_t;

    typedef struct packed {
        logic is_div;
        logic div_zero;
    } kind_t;

    typedef struct packed {
        in_t   item;
        kind_t kind;
    } entry_t;

    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  neg;
        logic                  cmp;
        logic [DATA_WIDTH-1:0] res;
        logic [DIV_WIDTH-1:0]  quo;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dvs;
    } stage_t;

endpackage

/* rtl/core/fpa_front.sv */
`timescale 1ns / 1ps

module fpa_front (
    input  fpa_pkg::in_t    in_item,
    output fpa_pkg::entry_t out_entry
);

    // classify: flag divide and divide by zero for the back end
    always_comb begin
        out_entry.item          = in_item;
        out_entry.kind.is_div   = (fpa_pkg::func_t'(in_item.func) == fpa_pkg::FN_DIV);
        out_entry.kind.div_zero = out_entry.kind.is_div
                                  && (in_item.operand_b == '0);
    end

endmodule

/* rtl/core/fpa_fifo.sv */
`timescale 1ns / 1ps

module fpa_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  fpa_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output fpa_pkg::entry_t head
);

    fpa_pkg::entry_t                 mem_reg [fpa_pkg::FIFO_DEPTH];
    logic [fpa_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fpa_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fpa_pkg::FIFO_CW-1:0]     cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    assign full    = (cnt_reg == fpa_pkg::FIFO_CW'(fpa_pkg::FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == fpa_pkg::FIFO_AW'(fpa_pkg::FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == fpa_pkg::FIFO_AW'(fpa_pkg::FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/fpa_back.sv */
`timescale 1ns / 1ps

module fpa_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  fpa_pkg::entry_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output fpa_pkg::out_t   m_data
);

    localparam int DW = fpa_pkg::DATA_WIDTH;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int QW = fpa_pkg::DIV_WIDTH;

    fpa_pkg::stage_t st_reg  [QW+1];
    fpa_pkg::stage_t st_next [QW+1];
    logic            vld_reg [QW+1];
    fpa_pkg::out_t   out_reg, out_next;
    logic            out_vld_reg;
    logic            en;

    logic signed [DW-1:0]   a, b;
    logic signed [2*DW-1:0] prod;
    logic [DW-1:0]          amag, bmag;

    // whole pipeline moves together; output register frees the chain
    assign en      = !out_vld_reg || m_ready;
    assign pop     = en;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    assign a    = head.item.operand_a;
    assign b    = head.item.operand_b;
    assign prod = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{b[DW-1]}}, b});
    assign amag = a[DW-1] ? (~a + 1'b1) : a;
    assign bmag = b[DW-1] ? (~b + 1'b1) : b;

    // first stage: non-divide ops, product and divider setup
    always_comb begin
        st_next[0]        = '0;
        st_next[0].is_div = head.kind.is_div;
        st_next[0].dz     = head.kind.div_zero;
        st_next[0].neg    = a[DW-1] ^ b[DW-1];
        st_next[0].quo    = {amag, {FB{1'b0}}};
        st_next[0].rem    = '0;
        st_next[0].dvs    = bmag;
        unique case (fpa_pkg::func_t'(head.item.func))
            fpa_pkg::FN_ADD:      st_next[0].res = a + b;
            fpa_pkg::FN_SUB:      st_next[0].res = a - b;
            fpa_pkg::FN_MUL:      st_next[0].res = prod[DW+FB-1:FB];
            fpa_pkg::FN_DIV:      st_next[0].res = '0;
            fpa_pkg::FN_MIN:      st_next[0].res = (a < b) ? a : b;
            fpa_pkg::FN_MAX:      st_next[0].res = (a > b) ? a : b;
            fpa_pkg::FN_LT:       st_next[0].cmp = (a < b);
            fpa_pkg::FN_GT:       st_next[0].cmp = (a > b);
            fpa_pkg::FN_LE:       st_next[0].cmp = (a <= b);
            fpa_pkg::FN_GE:       st_next[0].cmp = (a >= b);
            fpa_pkg::FN_EQ:       st_next[0].cmp = (a == b);
            fpa_pkg::FN_NE:       st_next[0].cmp = (a != b);
            fpa_pkg::FN_INC:      st_next[0].res = a + 1'b1;
            fpa_pkg::FN_DEC:      st_next[0].res = a - 1'b1;
            fpa_pkg::FN_FROM_INT: st_next[0].res = {a[DW-FB-1:0], {FB{1'b0}}};
            fpa_pkg::FN_TO_INT:   st_next[0].res = DW'(a >>> FB);
        endcase
    end

    // one restoring quotient bit per stage
    for (genvar i = 1; i <= QW; i++) begin : g_div
        logic [DW:0] trial;
        always_comb begin
            trial      = {st_reg[i-1].rem, st_reg[i-1].quo[QW-1]};
            st_next[i] = st_reg[i-1];
            st_next[i].quo = {st_reg[i-1].quo[QW-2:0], 1'b0};
            if (trial >= {1'b0, st_reg[i-1].dvs}) begin
                st_next[i].rem    = DW'(trial - {1'b0, st_reg[i-1].dvs});
                st_next[i].quo[0] = 1'b1;
            end else begin
                st_next[i].rem = trial[DW-1:0];
            end
        end
    end

    always_comb begin
        out_next.compare_flag   = st_reg[QW].cmp;
        out_next.divide_by_zero = st_reg[QW].dz;
        if (!st_reg[QW].is_div) begin
            out_next.result_value = st_reg[QW].res;
        end else if (st_reg[QW].dz) begin
            out_next.result_value = '0;
        end else if (st_reg[QW].neg) begin
            out_next.result_value = ~st_reg[QW].quo[DW-1:0] + 1'b1;
        end else begin
            out_next.result_value = st_reg[QW].quo[DW-1:0];
        end
    end

    for (genvar i = 0; i <= QW; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= (i == 0) ? head_valid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/core/fixed_point_q24_8_alu.sv */
`timescale 1ns / 1ps
// channel  | ports                      | payload
// input    | s_valid s_ready s_data     | fpa_pkg::in_t  (func, operand_a, operand_b)
// result   | m_valid m_ready m_data     | fpa_pkg::out_t (result_value, compare_flag,
//          |                            |                 divide_by_zero)
// one transfer per cycle in each direction when the result side keeps up
// every Q24.8 operation takes the same path: queue, setup
//   stage, one restoring quotient bit per stage over the 40-bit dividend, output register
// synchronous active-low reset empties the queue and the pipeline
// a stall on m_ready holds the back pipeline; the queue keeps taking items until full

module fixed_point_q24_8_alu (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fpa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fpa_pkg::out_t m_data
);

    fpa_pkg::entry_t push_entry;  // classified input item
    fpa_pkg::entry_t head;        // oldest queued item
    logic            full;
    logic            empty;
    logic            pop;

    assign s_ready = !full;

    // front: decode the operation class
    fpa_front u_front (
        .in_item   (s_data),
        .out_entry (push_entry)
    );

    // short queue lets the front accept while the back stalls
    fpa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (push_entry),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    // back: arithmetic pipeline with the bit-per-stage divider
    fpa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!empty),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // divide by zero always returns a zero value and no compare outcome
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.divide_by_zero) |->
            (m_data.result_value == '0) && !m_data.compare_flag)
        else $error("divide by zero result not cleared");

    // a compare outcome comes with a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.compare_flag) |-> (m_data.result_value == '0))
        else $error("compare result carries a value");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import fpa_pkg::*;

    localparam int LATENCY     = DIV_WIDTH + 3;
    localparam int N_RANDOM    = 1100;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    // items waiting to be offered, and results predicted but not yet seen
    in_t   pending_ops[$];
    out_t  expected_results[$];
    int    error_count;
    int    idle_cycles;
    int    cycle_count;
    int    hold_count;
    bit    stim_done;
    bit    quiet_phase;

    fixed_point_q24_8_alu dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // golden arithmetic on 64-bit signed intermediates, wrapped to the word
    function automatic out_t alu_predict(in_t it);
        out_t            r;
        longint          a;
        longint          b;
        longint          v;
        logic [63:0]     p;
        a = longint'(it.operand_a);
        b = longint'(it.operand_b);
        v = 0;
        r = '0;
        case (func_t'(it.func))
            FN_ADD:      v = a + b;
            FN_SUB:      v = a - b;
            FN_MUL: begin
                p = a * b;
                v = $signed(p) >>> FRAC_BITS;
            end
            FN_DIV: begin
                if (b == 0) r.divide_by_zero = 1'b1;
                else v = (a * (64'sd1 <<< FRAC_BITS)) / b;
            end
            FN_MIN:      v = (a < b) ? a : b;
            FN_MAX:      v = (a > b) ? a : b;
            FN_LT:       r.compare_flag = (a < b);
            FN_GT:       r.compare_flag = (a > b);
            FN_LE:       r.compare_flag = (a <= b);
            FN_GE:       r.compare_flag = (a >= b);
            FN_EQ:       r.compare_flag = (a == b);
            FN_NE:       r.compare_flag = (a != b);
            FN_INC:      v = a + 1;
            FN_DEC:      v = a - 1;
            FN_FROM_INT: v = a * (64'sd1 <<< FRAC_BITS);
            default:     v = a >>> FRAC_BITS;
        endcase
        r.result_value = v[DATA_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'd0;
            3:       return 32'($signed($urandom_range(0, 1024)) - 512);
            4:       return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
            5:       return {24'($signed($urandom_range(0, 200)) - 100), 8'h00};
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t make_op(func_t f, logic [31:0] a, logic [31:0] b);
        in_t it;
        it.func      = f;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    // stimulus: directed corner cases first, then random operations
    initial begin
        logic [31:0] ra;
        pending_ops.push_back(make_op(FN_ADD, 32'h7fff_ffff, 32'h0000_0001));
        pending_ops.push_back(make_op(FN_SUB, 32'h8000_0000, 32'h0000_0001));
        pending_ops.push_back(make_op(FN_MUL, 32'h8000_0000, 32'h8000_0000));
        pending_ops.push_back(make_op(FN_MUL, 32'hffff_ff00, 32'h0000_0001));
        pending_ops.push_back(make_op(FN_DIV, 32'h0000_0500, 32'h0000_0000));
        pending_ops.push_back(make_op(FN_DIV, 32'h8000_0000, 32'hffff_ff00));
        pending_ops.push_back(make_op(FN_DIV, 32'h8000_0000, 32'hffff_ffff));
        pending_ops.push_back(make_op(FN_DIV, 32'hffff_fd00, 32'h0000_0200));
        pending_ops.push_back(make_op(FN_DIV, 32'h7fff_ffff, 32'h0000_0001));
        pending_ops.push_back(make_op(FN_MIN, 32'h0000_0100, 32'h0000_0100));
        pending_ops.push_back(make_op(FN_MAX, 32'h8000_0000, 32'h7fff_ffff));
        pending_ops.push_back(make_op(FN_LT,  32'h8000_0000, 32'h7fff_ffff));
        pending_ops.push_back(make_op(FN_GT,  32'h8000_0000, 32'h7fff_ffff));
        pending_ops.push_back(make_op(FN_LE,  32'h1234_5678, 32'h1234_5678));
        pending_ops.push_back(make_op(FN_GE,  32'hffff_ffff, 32'h0000_0000));
        pending_ops.push_back(make_op(FN_EQ,  32'h1234_5678, 32'h1234_5678));
        pending_ops.push_back(make_op(FN_NE,  32'h1234_5678, 32'h1234_5679));
        pending_ops.push_back(make_op(FN_INC, 32'h7fff_ffff, 32'hffff_ffff));
        pending_ops.push_back(make_op(FN_DEC, 32'h8000_0000, 32'h0000_0000));
        pending_ops.push_back(make_op(FN_FROM_INT, 32'h00ff_ffff, 32'h0));
        pending_ops.push_back(make_op(FN_FROM_INT, 32'hff80_0000, 32'h0));
        pending_ops.push_back(make_op(FN_TO_INT, 32'h8000_0000, 32'h0));
        pending_ops.push_back(make_op(FN_TO_INT, 32'hffff_ffff, 32'h0));
        for (int i = 0; i < N_RANDOM; i++) begin
            ra = rand_operand();
            pending_ops.push_back(make_op(func_t'($urandom_range(0, 15)), ra,
                ($urandom_range(0, 9) == 0) ? ra : rand_operand()));
        end
        stim_done = 1'b1;
    end

    // reset held low first, then released; inputs known from time zero
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        cycle_count = 0;
        hold_count  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // a stretch with no random idling on either side
    always_comb quiet_phase = (cycle_count > 600 && cycle_count < 1000);

    // driver: keeps valid and payload steady until the transfer completes
    always @(posedge aclk) begin
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 &&
                    (quiet_phase || $urandom_range(0, 99) >= 29)) begin
                    in_t nxt;
                    nxt = pending_ops.pop_front();
                    expected_results.push_back(alu_predict(nxt));
                    s_data  <= nxt;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold-off so the queue fills and s_ready drops
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cycle_count >= 1200 && hold_count < HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= quiet_phase || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_data);
                error_count = error_count + 1;
            end else begin
                out_t exp_r;
                exp_r = expected_results.pop_front();
                if (m_data.result_value !== exp_r.result_value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, exp_r.result_value, m_data.result_value);
                    error_count = error_count + 1;
                end
                if (m_data.compare_flag !== exp_r.compare_flag) begin
                    $display("%0t: compare_flag expected %b actual %b",
                             $time, exp_r.compare_flag, m_data.compare_flag);
                    error_count = error_count + 1;
                end
                if (m_data.divide_by_zero !== exp_r.divide_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, exp_r.divide_by_zero, m_data.divide_by_zero);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // end of run: everything sent and drained, then a settling wait
    initial begin
        @(posedge aresetn);
        while (!(stim_done && pending_ops.size() == 0 && !s_valid &&
                 expected_results.size() == 0) && idle_cycles < STALL_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
        end else begin
            repeat (LATENCY + 10) @(posedge aclk);
            if (error_count == 0 && expected_results.size() == 0) begin
                $display("*** PASSED ***");
            end else begin
                $display("*** FAILED ***");
            end
        end
        $finish;
    end

endmodule
